@@ rtl/rc4sc_pkg.sv @@
// Package for the RC4 stream cipher unit: widths, sizes and request codes.
// Used by rc4_stream_cipher_unit; no dependencies.
package rc4sc_pkg;

   localparam int BYTE_W            = 8;
   localparam int PERM_DEPTH        = 256;
   localparam int PERM_AW           = 8;
   localparam int KCNT_W            = 9;
   localparam int MAX_KEY_BYTES_DEF = 256;

   // Request function codes
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

endpackage

@@ rtl/rc4sc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rc4sc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rc4_stream_cipher_unit.sv @@
// RC4 stream cipher unit: key loading, key scheduling and keystream XOR.
// Depends on rc4sc_pkg and rc4sc_ram (permutation memory and key memory).
//
//   channel | direction | ports                                  | moves
//   req     | in        | req_func, req_in_byte, req_key_last    | key byte or data byte
//   rsp     | out       | rsp_out_byte                           | data XOR keystream
//
// A data request makes three dependent reads (S[i], S[j], S[S[i]+S[j]]) in turn on
// the one read port of the permutation memory (ST_D2, ST_D3, ST_D4); the next request
// is taken in the cycle the result is loaded, not before. A key byte is stored in
// the key memory; the last key byte starts an identity fill, then key scheduling
// through ST_KADD, ST_KSWP and ST_KFIN for each entry.
// After reset a fill loads the identity permutation; req_ready is low.
// A stalled rsp holds the last stage and blocks the next request.
module rc4_stream_cipher_unit #(
   parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [rc4sc_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                          req_key_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rc4sc_pkg::BYTE_W-1:0]  rsp_out_byte
);

   import rc4sc_pkg::*;

   localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_D2,
      ST_D3,
      ST_D4,
      ST_KADD,
      ST_KSWP,
      ST_KFIN
   } st_type;

   st_type              state_ff, state_in;
   logic [PERM_AW-1:0]  cnt_ff, cnt_in;
   logic                sched_ff, sched_in;
   logic [PERM_AW-1:0]  i_ff, i_in;
   logic [PERM_AW-1:0]  j_ff, j_in;
   logic [KCNT_W-1:0]   key_count_ff, key_count_in;
   logic [KEY_AW-1:0]   kidx_ff, kidx_in;
   logic [BYTE_W-1:0]   acc_ff, acc_in;
   logic [BYTE_W-1:0]   si_ff, si_in;
   logic [PERM_AW-1:0]  t_ff, t_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [BYTE_W-1:0]   fwd_data_ff, fwd_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;

   logic                perm_we, perm_re;
   logic [PERM_AW-1:0]  perm_waddr, perm_raddr;
   logic [BYTE_W-1:0]   perm_wdata, perm_rd, perm_rd_eff;
   logic                key_we;
   logic [BYTE_W-1:0]   key_rd;
   logic                out_free;
   logic                accept;
   logic [BYTE_W-1:0]   sum_acc;
   logic [BYTE_W-1:0]   keystream;

   // Permutation memory
   rc4sc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_waddr),
      .wr_data (perm_wdata),
      .rd_en   (perm_re),
      .rd_addr (perm_raddr),
      .rd_data (perm_rd)
   );

   // Key memory
   rc4sc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_KEY_BYTES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_count_ff[KEY_AW-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (1'b1),
      .rd_addr (kidx_in),
      .rd_data (key_rd)
   );

   // Forward a write that hit the address read in the same cycle
   assign perm_rd_eff = fwd_hit_ff ? fwd_data_ff : perm_rd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign sum_acc   = acc_ff + perm_rd_eff + key_rd;
   assign keystream = (t_ff == j_ff) ? si_ff : perm_rd_eff;

   // Next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sched_in     = sched_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_count_in = key_count_ff;
      kidx_in      = kidx_ff;
      acc_in       = acc_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      perm_we      = 1'b0;
      perm_waddr   = cnt_ff;
      perm_wdata   = cnt_ff;
      perm_re      = 1'b1;
      perm_raddr   = i_ff + PERM_AW'(1);
      key_we       = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // Fill identity, one entry a cycle
            perm_we    = 1'b1;
            perm_raddr = '0;
            cnt_in     = cnt_ff + PERM_AW'(1);
            if (cnt_ff == PERM_AW'(PERM_DEPTH - 1)) begin
               state_in = sched_ff ? ST_KADD : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_D2: begin
            // S[i] is back: advance j, read S[j]
            si_in      = perm_rd_eff;
            j_in       = j_ff + perm_rd_eff;
            perm_raddr = j_ff + perm_rd_eff;
            state_in   = ST_D3;
         end
         ST_D3: begin
            // S[j] is back: write S[i] = S[j], read S[S[i]+S[j]]
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd_eff;
            perm_raddr = si_ff + perm_rd_eff;
            t_in       = si_ff + perm_rd_eff;
            state_in   = ST_D4;
         end
         ST_D4: begin
            // Write S[j] = old S[i], load the result
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ keystream;
               state_in     = ST_IDLE;
               req_ready    = 1'b1;
            end else begin
               perm_re = 1'b0;
            end
         end
         ST_KADD: begin
            // acc += S[k] + key; read S[acc]
            acc_in     = sum_acc;
            si_in      = perm_rd_eff;
            perm_raddr = sum_acc;
            state_in   = ST_KSWP;
         end
         ST_KSWP: begin
            // S[k] = S[acc]
            perm_we    = 1'b1;
            perm_waddr = cnt_ff;
            perm_wdata = perm_rd_eff;
            state_in   = ST_KFIN;
         end
         ST_KFIN: begin
            // S[acc] = old S[k]; read the next entry and key byte
            perm_we    = 1'b1;
            perm_waddr = acc_ff;
            perm_wdata = si_ff;
            perm_raddr = cnt_ff + PERM_AW'(1);
            cnt_in     = cnt_ff + PERM_AW'(1);
            if (KCNT_W'(kidx_ff) + KCNT_W'(1) == key_count_ff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + KEY_AW'(1);
            end
            if (cnt_ff == PERM_AW'(PERM_DEPTH - 1)) begin
               state_in     = ST_IDLE;
               i_in         = '0;
               j_in         = '0;
               key_count_in = '0;
               sched_in     = 1'b0;
            end else begin
               state_in = ST_KADD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Take a request
      if (accept) begin
         if (req_func == FUNC_DATA) begin
            data_in  = req_in_byte;
            i_in     = i_ff + PERM_AW'(1);
            state_in = ST_D2;
         end else begin
            if (key_count_ff < KCNT_W'(MAX_KEY_BYTES)) begin
               key_we       = 1'b1;
               key_count_in = key_count_ff + KCNT_W'(1);
            end
            if (req_key_last) begin
               state_in = ST_INIT;
               sched_in = 1'b1;
               cnt_in   = '0;
               acc_in   = '0;
               kidx_in  = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
      end

      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (perm_re) begin
         fwd_hit_in  = perm_we && (perm_waddr == perm_raddr);
         fwd_data_in = perm_wdata;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         sched_ff     <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         key_count_ff <= '0;
         kidx_ff      <= '0;
         acc_ff       <= '0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sched_ff     <= sched_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_count_ff <= key_count_in;
         kidx_ff      <= kidx_in;
         acc_ff       <= acc_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      si_ff       <= si_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      fwd_data_ff <= fwd_data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule

@@ bench/tb_rc4_stream_cipher_unit.sv @@
// Self-checking bench for rc4_stream_cipher_unit: random key and data requests with
// a keystream predictor checked against every response byte.
// Depends on rc4sc_pkg and the rc4_stream_cipher_unit RTL.
module tb_rc4_stream_cipher_unit;
   import rc4sc_pkg::*;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data;
      logic              last;
   } cipher_req_type;

   localparam int KEY_LIMIT  = MAX_KEY_BYTES_DEF;
   localparam int CALM_DEPTH = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_func = FUNC_KEY;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              req_key_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;

   // Predictor state: permutation, key bytes, key length, generator indices
   logic [BYTE_W-1:0] sbox[PERM_DEPTH];
   logic [BYTE_W-1:0] key_mem[PERM_DEPTH];
   int unsigned       key_len = 0;
   logic [BYTE_W-1:0] gen_i = '0;
   logic [BYTE_W-1:0] gen_j = '0;

   cipher_req_type    pending_reqs[$];
   logic [BYTE_W-1:0] expected_bytes[$];

   int  send_gap = 0;
   int  recv_stall = 0;
   int  bytes_checked = 0;
   int  items_queued = 0;
   bit  quiet = 1'b0;
   bit  hold_off = 1'b0;
   bit  failed = 1'b0;

   rc4_stream_cipher_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_in_byte  (req_in_byte),
      .req_key_last (req_key_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Rebuild the permutation from the stored key and clear the indices and key length
   function automatic void ks_schedule();
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] kb;
      logic [BYTE_W-1:0] tmp;
      acc = '0;
      for (int k = 0; k < PERM_DEPTH; k++) sbox[k] = 8'(k);
      for (int k = 0; k < PERM_DEPTH; k++) begin
         kb = (key_len != 0) ? key_mem[k % key_len] : '0;
         acc = acc + sbox[k] + kb;
         tmp = sbox[k];
         sbox[k] = sbox[acc];
         sbox[acc] = tmp;
      end
      gen_i = '0;
      gen_j = '0;
      key_len = 0;
   endfunction

   // Step the generator once and return the keystream byte
   function automatic logic [BYTE_W-1:0] ks_next_byte();
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] pick;
      gen_i = gen_i + 8'd1;
      gen_j = gen_j + sbox[gen_i];
      tmp = sbox[gen_i];
      sbox[gen_i] = sbox[gen_j];
      sbox[gen_j] = tmp;
      pick = sbox[gen_i] + sbox[gen_j];
      return sbox[pick];
   endfunction

   // Apply one accepted request to the predictor
   function automatic void ks_apply_request(cipher_req_type r);
      logic [BYTE_W-1:0] pred;
      if (r.func == FUNC_KEY) begin
         if (key_len < KEY_LIMIT) begin
            key_mem[key_len] = r.data;
            key_len++;
         end
         if (r.last) ks_schedule();
      end else begin
         pred = r.data ^ ks_next_byte();
         expected_bytes = {expected_bytes, pred};
      end
   endfunction

   function automatic void queue_req(logic func, logic [BYTE_W-1:0] data, logic last);
      cipher_req_type r;
      r.func = func;
      r.data = data;
      r.last = last;
      pending_reqs = {pending_reqs, r};
      items_queued++;
   endfunction

   // Queue a key of the given length; the final byte carries key_last only if closed is set
   function automatic void queue_key(int len, bit closed);
      for (int k = 0; k < len; k++)
         queue_req(FUNC_KEY, 8'($urandom_range(0, 255)), closed && (k == len - 1));
   endfunction

   function automatic void queue_data(int count);
      for (int k = 0; k < count; k++)
         queue_req(FUNC_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endfunction

   // Drive requests from the pending queue, with random gaps until the tail
   always @(posedge clock) begin : drive_req
      cipher_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            nxt.func = req_func;
            nxt.data = req_in_byte;
            nxt.last = req_key_last;
            ks_apply_request(nxt);
         end
         if (req_valid && !req_ready) begin
            // hold the offered request
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 && !quiet && $urandom_range(0, 99) < 10) begin
            send_gap <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_func <= nxt.func;
            req_in_byte <= nxt.data;
            req_key_last <= nxt.last;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         quiet <= (pending_reqs.size() < CALM_DEPTH);
      end
   end

   // Check each response byte and pick the next ready value
   always @(posedge clock) begin : check_rsp
      logic [BYTE_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected none, actual %02h", rsp_out_byte);
               failed = 1'b1;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want) begin
                  $error("out_byte: expected %02h, actual %02h", want, rsp_out_byte);
                  failed = 1'b1;
               end
            end
            bytes_checked++;
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 8) begin
            recv_stall <= $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Back-pressure: hold off the response side long enough to stall requests
   initial begin
      while (bytes_checked < 5) @(posedge clock);
      hold_off <= 1'b1;
      repeat (200) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #(20 * 1_000_000);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int pick;
      for (int k = 0; k < PERM_DEPTH; k++) sbox[k] = 8'(k);

      // Data before any key runs on the identity permutation; key_last is ignored
      queue_req(FUNC_DATA, 8'h00, 1'b0);
      queue_req(FUNC_DATA, 8'hFF, 1'b1);
      queue_req(FUNC_DATA, 8'h80, 1'b0);
      queue_req(FUNC_DATA, 8'h01, 1'b1);
      queue_data(8);
      // Shortest key, all-zero byte
      queue_req(FUNC_KEY, 8'h00, 1'b1);
      queue_req(FUNC_DATA, 8'h00, 1'b0);
      queue_req(FUNC_DATA, 8'hFF, 1'b0);
      queue_data(2);
      // Two-byte all-ones key, then a fresh key after two data requests
      queue_req(FUNC_KEY, 8'hFF, 1'b0);
      queue_req(FUNC_KEY, 8'hFF, 1'b1);
      queue_data(2);
      queue_req(FUNC_KEY, 8'h5A, 1'b1);
      queue_data(3);

      // Random traffic: mostly key-then-data sessions, some stray and broken ones
      while (items_queued < 1350) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 99) < 4) queue_key($urandom_range(240, 300), 1'b1);
            else queue_key($urandom_range(1, 16), 1'b1);
            queue_data($urandom_range(5, 40));
         end else if (pick < 85) begin
            queue_data($urandom_range(1, 20));
         end else if (pick < 95) begin
            // open key, later merged into the next one
            queue_key($urandom_range(1, 8), 1'b0);
         end else begin
            queue_key(KEY_LIMIT, 1'b1);
            queue_data($urandom_range(5, 20));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every byte back, then a few spare cycles
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
